// ----- rtl/core/rgb2yuv_pkg.sv -----
package rgb2yuv_pkg;

  localparam int unsigned LineWidthW   = 13;
  localparam int unsigned ColW         = 12;
  localparam int unsigned MaxLineWidth = 4096;
  localparam int unsigned MinLineWidth = 2;

  localparam logic [LineWidthW-1:0] LINE_WIDTH_RESET = 13'd640;
  localparam logic [LineWidthW-1:0] LINE_WIDTH_MAX   = LineWidthW'(MaxLineWidth);
  localparam logic [LineWidthW-1:0] LINE_WIDTH_MIN   = LineWidthW'(MinLineWidth);

  // Luma coefficients, all positive.
  localparam logic [16:0] Y_R = 17'd66;
  localparam logic [16:0] Y_G = 17'd129;
  localparam logic [16:0] Y_B = 17'd25;
  localparam logic [16:0] Y_RND = 17'd128;

  // Chroma coefficients; the bias lifts every sum above zero.
  localparam logic signed [17:0] U_R  = -18'sd38;
  localparam logic signed [17:0] U_G  = -18'sd74;
  localparam logic signed [17:0] U_B  = 18'sd112;
  localparam logic signed [17:0] V_R  = 18'sd112;
  localparam logic signed [17:0] V_G  = -18'sd94;
  localparam logic signed [17:0] V_B  = -18'sd18;
  localparam logic signed [17:0] C_RND_BIAS = 18'sd32896;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic       chroma_valid;
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] luma;
  } yuv_t;

endpackage

// ----- rtl/core/rgb2yuv_phase.sv -----
module rgb2yuv_phase (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic                               frame_start,
  input  logic [rgb2yuv_pkg::LineWidthW-1:0] line_width,
  output logic                               chroma_sample
);
  import rgb2yuv_pkg::*;

  logic [ColW-1:0]       column_r;
  logic [ColW-1:0]       column_nxt;
  logic                  second_row_r;
  logic                  second_row_nxt;
  logic [ColW-1:0]       column_base;
  logic                  second_row_base;
  logic [LineWidthW-1:0] column_inc;
  logic [LineWidthW-1:0] width_eff;

  always_comb begin
    if (line_width < LINE_WIDTH_MIN) begin
      width_eff = LINE_WIDTH_MIN;
    end else if (line_width > LINE_WIDTH_MAX) begin
      width_eff = LINE_WIDTH_MAX;
    end else begin
      width_eff = line_width;
    end
  end

  always_comb begin
    column_base     = frame_start ? '0 : column_r;
    second_row_base = frame_start ? 1'b0 : second_row_r;
    chroma_sample   = !second_row_base && !column_base[0];
    column_inc      = LineWidthW'(column_base) + LineWidthW'(1);
    if (column_inc >= width_eff) begin
      column_nxt     = '0;
      second_row_nxt = !second_row_base;
    end else begin
      column_nxt     = column_inc[ColW-1:0];
      second_row_nxt = second_row_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      second_row_r <= 1'b0;
    end else if (advance) begin
      column_r     <= column_nxt;
      second_row_r <= second_row_nxt;
    end
  end

endmodule

// ----- rtl/core/rgb2yuv_math.sv -----
module rgb2yuv_math (
  input  rgb2yuv_pkg::rgb_t pixel,
  input  logic              chroma_sample,
  output rgb2yuv_pkg::yuv_t result
);
  import rgb2yuv_pkg::*;

  logic [16:0]        luma_sum;
  logic signed [17:0] r_s;
  logic signed [17:0] g_s;
  logic signed [17:0] b_s;
  logic signed [17:0] u_sum;
  logic signed [17:0] v_sum;

  always_comb begin
    luma_sum = Y_R * 17'(pixel.red) + Y_G * 17'(pixel.green) + Y_B * 17'(pixel.blue) + Y_RND;
    r_s   = signed'({10'b0, pixel.red});
    g_s   = signed'({10'b0, pixel.green});
    b_s   = signed'({10'b0, pixel.blue});
    u_sum = U_R * r_s + U_G * g_s + U_B * b_s + C_RND_BIAS;
    v_sum = V_R * r_s + V_G * g_s + V_B * b_s + C_RND_BIAS;

    result.luma         = luma_sum[15:8];
    result.chroma_valid = chroma_sample;
    result.cb           = chroma_sample ? u_sum[15:8] : 8'd0;
    result.cr           = chroma_sample ? v_sum[15:8] : 8'd0;
  end

endmodule

// ----- rtl/core/rgb_to_yuv420_converter.sv -----
// Pipeline: input register, then result register.
// Throughput: one pixel per cycle while out_tready does not stall the result register;
// the constant-coefficient multiply-add between the two registers sets the path.
// Reset (rst_n, synchronous, active low): pipeline empty, column and row phase
// cleared, line_width back to 640.
module rgb_to_yuv420_converter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rgb2yuv_pkg::LineWidthW-1:0] cfg_data,   // line_width
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,   // blue, green, red
  input  logic                               in_tuser,   // frame_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,  // luma, cb, cr
  output logic                               out_tuser   // chroma_valid
);
  import rgb2yuv_pkg::*;

  logic [LineWidthW-1:0] line_width_r;
  logic                  s1_valid_r;
  rgb_t                  s1_pixel_r;
  logic                  s1_chroma_r;
  logic                  out_valid_r;
  yuv_t                  out_result_r;
  yuv_t                  result;
  logic                  in_beat;
  logic                  out_load;
  logic                  chroma_sample;
  rgb_t                  in_pixel;

  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_load;
  assign in_beat   = in_tvalid && in_tready;

  assign in_pixel.blue  = in_tdata[7:0];
  assign in_pixel.green = in_tdata[15:8];
  assign in_pixel.red   = in_tdata[23:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_width_r <= cfg_data;
    end
  end

  rgb2yuv_phase u_phase (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (in_beat),
    .frame_start   (in_tuser),
    .line_width    (line_width_r),
    .chroma_sample (chroma_sample)
  );

  // Hold the input stage until the result register frees up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_pixel_r  <= in_pixel;
      s1_chroma_r <= chroma_sample;
    end
  end

  rgb2yuv_math u_math (
    .pixel         (s1_pixel_r),
    .chroma_sample (s1_chroma_r),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_result_r.cr, out_result_r.cb, out_result_r.luma};
  assign out_tuser  = out_result_r.chroma_valid;

endmodule

// ----- bench/tb_rgb_to_yuv420_converter.sv -----
`timescale 1ns / 1ps

module tb_rgb_to_yuv420_converter;
  import rgb2yuv_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [LineWidthW-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;   // blue, green, red
  logic                  in_tuser;   // frame_start
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;  // luma, cb, cr
  logic                  out_tuser;  // chroma_valid

  rgb_to_yuv420_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // width < 0 keeps the current line_width; typed rows carry their own result
  typedef struct {
    int width;
    int red;
    int green;
    int blue;
    bit fs;
    bit typed;
    int luma;
    int cv;
    int cb;
    int cr;
  } pixel_row_t;

  localparam int NumRows = 25;

  pixel_row_t pixel_table [NumRows] = '{
    '{  -1,   0,   0,   0, 1, 1,   0, 1, 128, 128},
    '{  -1, 255, 255, 255, 0, 1, 219, 0,   0,   0},
    '{  -1, 255,   0,   0, 0, 1,  66, 1,  90, 240},
    '{  -1,   0, 255,   0, 0, 1, 128, 0,   0,   0},
    '{  -1,   0,   0, 255, 0, 1,  25, 1, 240, 110},
    '{  -1, 255, 255, 255, 1, 1, 219, 1, 128, 128},
    '{  -1,   0, 255,   0, 0, 1, 128, 0,   0,   0},
    '{   3,  10,  20,  30, 1, 0,   0, 0,   0,   0},
    '{  -1, 200, 100,  50, 0, 0,   0, 0,   0,   0},
    '{  -1,   1, 254, 128, 0, 0,   0, 0,   0,   0},
    '{  -1,  77,  33, 199, 0, 0,   0, 0,   0,   0},
    '{  -1, 128, 128, 128, 0, 0,   0, 0,   0,   0},
    '{  -1,   5, 250,   5, 0, 0,   0, 0,   0,   0},
    '{  -1, 250,   5, 250, 0, 0,   0, 0,   0,   0},
    '{   0,  17,  34,  51, 0, 0,   0, 0,   0,   0},
    '{  -1,  99,   0, 255, 0, 0,   0, 0,   0,   0},
    '{  -1,   0,  99, 255, 0, 0,   0, 0,   0,   0},
    '{   1, 255, 128,   0, 1, 0,   0, 0,   0,   0},
    '{  -1,  60,  60,  60, 0, 0,   0, 0,   0,   0},
    '{  -1, 255,   0, 255, 0, 0,   0, 0,   0,   0},
    '{8191, 128,   0, 128, 1, 0,   0, 0,   0,   0},
    '{  -1,   0, 128, 255, 0, 0,   0, 0,   0,   0},
    '{   2,  33,  66,  99, 1, 0,   0, 0,   0,   0},
    '{  -1, 240,  16, 240, 0, 0,   0, 0,   0,   0},
    '{  -1,  16, 240,  16, 0, 0,   0, 0,   0,   0}
  };

  logic [LineWidthW-1:0] line_width_reg;
  int                    col_pos;
  bit                    lower_row;
  yuv_t                  yuv_expected [$];
  int                    fault_count;
  bit                    src_burst;
  bit                    sink_burst;
  int                    stall_left;

  function automatic yuv_t convert_pixel(rgb_t px, bit fs);
    int   r;
    int   g;
    int   b;
    int   eff;
    int   sy;
    int   su;
    int   sv;
    yuv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    eff = int'(line_width_reg);
    if (eff < 2) eff = 2;
    if (eff > int'(MaxLineWidth)) eff = int'(MaxLineWidth);
    if (fs) begin
      col_pos = 0;
      lower_row = 1'b0;
    end
    res = '0;
    sy = 66 * r + 129 * g + 25 * b + 128;
    res.luma = 8'(sy >>> 8);
    if (!lower_row && (col_pos % 2 == 0)) begin
      su = -38 * r - 74 * g + 112 * b + 128 + 32768;
      sv = 112 * r - 94 * g - 18 * b + 128 + 32768;
      res.chroma_valid = 1'b1;
      res.cb = 8'(su >>> 8);
      res.cr = 8'(sv >>> 8);
    end
    col_pos++;
    if (col_pos >= eff) begin
      col_pos = 0;
      lower_row = !lower_row;
    end
    return res;
  endfunction

  function automatic int gap_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic rgb_t rand_pixel();
    rgb_t px;
    if ($urandom_range(0, 4) == 0) begin
      px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      px = 24'($urandom);
    end
    return px;
  endfunction

  // leaves in_tvalid high; the next call in the same step either keeps or drops it
  task automatic send_pixel(rgb_t px, bit fs, bit typed, yuv_t typed_res);
    int   gap;
    yuv_t res;
    gap = src_burst ? 0 : gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    res = convert_pixel(px, fs);
    yuv_expected.push_back(typed ? typed_res : res);
  endtask

  task automatic write_line_width(int unsigned w);
    in_tvalid <= 1'b0;
    while (yuv_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= LineWidthW'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    line_width_reg = LineWidthW'(w);
  endtask

  always @(posedge clk) begin
    yuv_t got;
    yuv_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (yuv_expected.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: unexpected beat luma=%0d cv=%0d cb=%0d cr=%0d", $realtime,
                   got.luma, got.chroma_valid, got.cb, got.cr);
        fault_count++;
      end else begin
        want = yuv_expected.pop_front();
        if (got.luma != want.luma || got.chroma_valid != want.chroma_valid ||
            got.cb != want.cb || got.cr != want.cr) begin
          if (fault_count < 10)
            $display("%0t: mismatch luma %0d/%0d cv %0d/%0d cb %0d/%0d cr %0d/%0d (exp/got)",
                     $realtime, want.luma, got.luma, want.chroma_valid, got.chroma_valid,
                     want.cb, got.cb, want.cr, got.cr);
          fault_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!sink_burst) stall_left = gap_cycles();
    end
  end

  initial begin
    #20_000_000;
    $display("rgb_to_yuv420_converter regression: fail");
    $finish;
  end

  initial begin
    rgb_t px;
    yuv_t res;
    int   rand_items;
    int   roll;
    int   w;
    int   n;
    bit   fs;
    int   wait_cycles;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    stall_left     = 0;
    src_burst      = 1'b0;
    sink_burst     = 1'b0;
    fault_count    = 0;
    line_width_reg = LINE_WIDTH_RESET;
    col_pos        = 0;
    lower_row      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      if (pixel_table[i].width >= 0) write_line_width(pixel_table[i].width);
      px.red   = 8'(pixel_table[i].red);
      px.green = 8'(pixel_table[i].green);
      px.blue  = 8'(pixel_table[i].blue);
      res = '0;
      res.luma         = 8'(pixel_table[i].luma);
      res.chroma_valid = pixel_table[i].cv[0];
      res.cb           = 8'(pixel_table[i].cb);
      res.cr           = 8'(pixel_table[i].cr);
      send_pixel(px, pixel_table[i].fs, pixel_table[i].typed, res);
    end

    rand_items = 0;
    while (rand_items < 760) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) w = $urandom_range(0, 1);
      else if (roll == 1) w = $urandom_range(2, 8191);
      else if (roll < 6) w = 2 * $urandom_range(1, 24);
      else w = $urandom_range(2, 40);
      write_line_width(w);
      src_burst  = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 120);
      for (int k = 0; k < n; k++) begin
        fs = ((k == 0) && ($urandom_range(0, 3) != 0)) || ($urandom_range(0, 99) == 0);
        send_pixel(rand_pixel(), fs, 1'b0, '0);
      end
      rand_items += n;
    end

    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (yuv_expected.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (yuv_expected.size() != 0) begin
      $display("%0d expected beats never arrived", yuv_expected.size());
      fault_count += yuv_expected.size();
    end
    if (fault_count == 0) begin
      $display("rgb_to_yuv420_converter regression: pass");
    end else begin
      $display("rgb_to_yuv420_converter regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rgb2yuv_pkg.sv
rtl/core/rgb2yuv_phase.sv
rtl/core/rgb2yuv_math.sv
rtl/core/rgb_to_yuv420_converter.sv
bench/tb_rgb_to_yuv420_converter.sv
